/* rtl/core/pcs_pkg.sv */
`timescale 1ns / 1ps
package pcs_pkg;

    localparam int TIME_W    = 40;
    localparam int RATE_W    = 48;
    localparam int GAIN_W    = 32;
    localparam int LOCK_W    = 32;
    localparam int INTEG_W   = 56;
    localparam int CFG_W     = 47;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;

    // Iterative arithmetic unit widths.
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 86;
    localparam int DIV_D_W = 40;
    localparam int MAG_W   = 61;
    localparam int TERM_W  = MAG_W + 1;
    localparam int LIM_W   = INTEG_W - 1;

    localparam logic [GAIN_W-1:0] NS_PER_SEC = 32'd1000000000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DRIFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_THR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FREQ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FADJ   = 3'd7;

    localparam logic [46:0] RST_MAX_DRIFT  = 47'd5898240000;
    localparam logic [46:0] RST_FREQ_THR   = 47'd655360000;
    localparam logic [38:0] RST_COARSE_THR = 39'd1000000;
    localparam logic [38:0] RST_LOCK_THR   = 39'd1000;
    localparam logic [31:0] RST_GAIN_FREQ  = 32'd268435456;
    localparam logic [31:0] RST_GAIN_PROP  = 32'd187904819;
    localparam logic [31:0] RST_GAIN_INTEG = 32'd80530637;
    localparam logic [46:0] RST_MAX_FADJ   = 47'd32768000000;

    typedef enum logic [2:0] {
        MODE_NONE      = 3'd0,
        MODE_DRIFT_ERR = 3'd1,
        MODE_FREQ      = 3'd2,
        MODE_COARSE    = 3'd3,
        MODE_FINE      = 3'd4
    } t_mode;

    typedef enum logic [1:0] {MS_NS, MS_KF, MS_KP, MS_KI} t_mul_sel;
    typedef enum logic {DS_DRIFT, DS_LIM} t_div_sel;
    typedef enum logic [1:0] {MD_FREQ, MD_PROP, MD_INTEG} t_mul_dst;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     q_latch;
        logic     mul_latch;
        t_mul_dst mul_dst;
        logic     lim_latch;
        logic     lim_zero;
        logic     integ_upd;
        logic     fin;
        t_mode    kind;
    } t_cmd;

    typedef struct packed {
        logic ref_zero;
        logic mul_done;
        logic div_done;
        logic drift_over;
        logic freq_sel;
        logic coarse_sel;
        logic ki_zero;
        logic out_free;
    } t_status;

endpackage

/* rtl/core/pcs_if.sv */
`timescale 1ns / 1ps
interface pcs_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcs_pkg::TIME_W-1:0]   ref_interval;
    logic signed [pcs_pkg::TIME_W-1:0]   local_interval;
    logic signed [pcs_pkg::TIME_W-1:0]   clock_offset;

    modport source (output valid, ref_interval, local_interval, clock_offset, input ready);
    modport sink (input valid, ref_interval, local_interval, clock_offset, output ready);
endinterface

interface pcs_out_if;
    logic                                valid;
    logic                                ready;
    logic        [pcs_pkg::MODE_W-1:0]   mode;
    logic                                adjust_frequency;
    logic                                step_clock;
    logic signed [pcs_pkg::RATE_W-1:0]   freq_adjust;
    logic signed [pcs_pkg::TIME_W-1:0]   offset_correction;
    logic signed [pcs_pkg::RATE_W-1:0]   measured_drift;
    logic signed [pcs_pkg::RATE_W-1:0]   freq_term;
    logic signed [pcs_pkg::RATE_W-1:0]   prop_term;
    logic signed [pcs_pkg::RATE_W-1:0]   integ_term;
    logic        [pcs_pkg::LOCK_W-1:0]   lock_count;

    modport source (output valid, mode, adjust_frequency, step_clock, freq_adjust,
                    offset_correction, measured_drift, freq_term, prop_term,
                    integ_term, lock_count, input ready);
    modport sink (input valid, mode, adjust_frequency, step_clock, freq_adjust,
                  offset_correction, measured_drift, freq_term, prop_term,
                  integ_term, lock_count, output ready);
endinterface

/* rtl/core/pcs_mul.sv */
`timescale 1ns / 1ps
module pcs_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcs_pkg::MUL_A_W-1:0]  i_a,
    input  logic [pcs_pkg::MUL_B_W-1:0]  i_b,
    output logic                         o_done,
    output logic [pcs_pkg::MUL_P_W-1:0]  o_prod
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_A_W:0]   n_sum;

    // Shift-and-add, one multiplier bit per cycle, least significant first.
    assign n_sum = {1'b0, r_acc[MUL_P_W-1:MUL_B_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_b   <= r_b >> 1;
            r_acc <= {n_sum, r_acc[MUL_B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

/* rtl/core/pcs_div.sv */
`timescale 1ns / 1ps
module pcs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcs_pkg::DIV_N_W-1:0]  i_num,
    input  logic [pcs_pkg::DIV_D_W-1:0]  i_den,
    output logic                         o_done,
    output logic [pcs_pkg::DIV_N_W-1:0]  o_quo
);
    import pcs_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_N_W-1:0] r_num;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W:0]   n_trial;
    logic               n_fits;

    // Restoring division, one quotient bit per cycle.
    assign n_trial = {r_rem, r_num[DIV_N_W-1]};
    assign n_fits  = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[DIV_N_W-2:0], n_fits};
            if (n_fits) begin
                r_rem <= DIV_D_W'(n_trial - {1'b0, r_den});
            end else begin
                r_rem <= n_trial[DIV_D_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* rtl/core/pcs_dp.sv */
`timescale 1ns / 1ps
module pcs_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [pcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic        [pcs_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic signed [pcs_pkg::TIME_W-1:0]    i_ref_interval,
    input  logic signed [pcs_pkg::TIME_W-1:0]    i_local_interval,
    input  logic signed [pcs_pkg::TIME_W-1:0]    i_clock_offset,
    input  pcs_pkg::t_cmd                        i_cmd,
    output pcs_pkg::t_status                     o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic        [pcs_pkg::MODE_W-1:0]    o_mode,
    output logic                                 o_adjust_frequency,
    output logic                                 o_step_clock,
    output logic signed [pcs_pkg::RATE_W-1:0]    o_freq_adjust,
    output logic signed [pcs_pkg::TIME_W-1:0]    o_offset_correction,
    output logic signed [pcs_pkg::RATE_W-1:0]    o_measured_drift,
    output logic signed [pcs_pkg::RATE_W-1:0]    o_freq_term,
    output logic signed [pcs_pkg::RATE_W-1:0]    o_prop_term,
    output logic signed [pcs_pkg::RATE_W-1:0]    o_integ_term,
    output logic        [pcs_pkg::LOCK_W-1:0]    o_lock_count
);
    import pcs_pkg::*;

    localparam logic signed [63:0] RATE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] RATE_MIN = -RATE_MAX - 64'sd1;
    localparam logic [LIM_W-1:0]   LIM_MAX  = '1;

    function automatic logic [TIME_W-1:0] mag_time(input logic [TIME_W-1:0] v);
        logic [TIME_W:0] ext;
        logic [TIME_W:0] m;
        ext = {v[TIME_W-1], v};
        m   = v[TIME_W-1] ? ((TIME_W+1)'(0) - ext) : ext;
        return m[TIME_W-1:0];
    endfunction

    // Magnitudes saturate at 2^60.
    function automatic logic [MAG_W-1:0] cap_mag(input logic [MUL_P_W-1:0] x);
        logic big;
        big = (|x[MUL_P_W-1:MAG_W]) || (x[MAG_W-1] && (|x[MAG_W-2:0]));
        return big ? {1'b1, {(MAG_W-1){1'b0}}} : x[MAG_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] sat_rate(input logic signed [63:0] x);
        logic signed [63:0] s;
        s = (x > RATE_MAX) ? RATE_MAX : ((x < RATE_MIN) ? RATE_MIN : x);
        return s[RATE_W-1:0];
    endfunction

    // Configuration registers.
    logic [46:0] r_max_drift, r_freq_thr, r_mfa;
    logic [38:0] r_coarse_thr, r_lock_thr;
    logic [31:0] r_kf, r_kp, r_ki;

    // Per-item working registers.
    logic [TIME_W-1:0]        r_ref_mag, r_dmag, r_omag, r_cmag;
    logic                     r_dneg;
    logic signed [TIME_W-1:0] r_corr;
    logic [MAG_W-1:0]         r_q;
    logic [LIM_W-1:0]         r_lim;
    logic signed [TERM_W-1:0] r_fterm, r_prop, r_iterm;

    // Servo state.
    logic signed [RATE_W-1:0]  r_da;
    logic signed [INTEG_W-1:0] r_integ;
    logic [LOCK_W-1:0]         r_lock;

    // Output register.
    logic                     r_o_valid;
    logic [MODE_W-1:0]        r_o_mode;
    logic                     r_o_adj, r_o_step;
    logic signed [RATE_W-1:0] r_o_fadj, r_o_meas, r_o_fterm, r_o_prop, r_o_iterm;
    logic signed [TIME_W-1:0] r_o_corr;
    logic [LOCK_W-1:0]        r_o_lock;

    // Arithmetic units.
    logic               w_mul_start, w_mul_done, w_div_done;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [MUL_P_W-1:0] w_prod;
    logic [DIV_N_W-1:0] w_div_num, w_quo;
    logic [DIV_D_W-1:0] w_div_den;

    // Load-time helpers.
    logic signed [TIME_W:0]  w_diff;
    logic [TIME_W:0]         w_diff_mag;
    logic signed [TIME_W-1:0] w_corr;
    logic [INTEG_W-1:0]      w_imag;

    // Update helpers.
    logic [MUL_P_W-1:0]         w_shifted;
    logic [MAG_W-1:0]           w_gmag;
    logic                       w_gneg;
    logic signed [TERM_W-1:0]   w_gterm;
    logic [MAG_W-1:0]           w_qcap;
    logic signed [INTEG_W:0]    w_isum, w_ilim, w_iclamp;
    logic signed [TERM_W:0]     w_dsum, w_mfa_s, w_dclamp;
    logic signed [TERM_W-1:0]   w_drift;
    logic signed [63:0]         w_total;
    logic                       w_lock_ok;
    logic [LOCK_W-1:0]          w_lock_inc;

    assign w_mul_start = i_cmd.mul_start;

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_NS:   begin w_mul_a = MUL_A_W'(r_dmag);         w_mul_b = NS_PER_SEC; end
            MS_KF:   begin w_mul_a = r_q[MUL_A_W-1:0];         w_mul_b = r_kf; end
            MS_KP:   begin w_mul_a = MUL_A_W'(r_cmag);         w_mul_b = r_kp; end
            default: begin w_mul_a = w_imag;                   w_mul_b = r_ki; end
        endcase
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_DRIFT: begin
                w_div_num = {w_prod[DIV_N_W-17:0], 16'b0};
                w_div_den = r_ref_mag;
            end
            default: begin
                w_div_num = DIV_N_W'({r_mfa, 12'b0});
                w_div_den = DIV_D_W'(r_ki);
            end
        endcase
    end

    pcs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    pcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_diff     = $signed({i_ref_interval[TIME_W-1], i_ref_interval})
                   - $signed({i_local_interval[TIME_W-1], i_local_interval});
        w_diff_mag = w_diff[TIME_W] ? ((TIME_W+1)'(0) - w_diff) : w_diff;
        w_corr     = (i_clock_offset == {1'b1, {(TIME_W-1){1'b0}}}) ?
                     {1'b0, {(TIME_W-1){1'b1}}} : (TIME_W'(0) - i_clock_offset);
        w_imag     = r_integ[INTEG_W-1] ? (INTEG_W'(0) - r_integ) : r_integ;

        w_shifted  = (i_cmd.mul_dst == MD_FREQ) ? (w_prod >> 28) : (w_prod >> 12);
        w_gmag     = cap_mag(w_shifted);
        unique case (i_cmd.mul_dst)
            MD_FREQ:  w_gneg = r_dneg;
            MD_PROP:  w_gneg = r_corr[TIME_W-1];
            default:  w_gneg = r_integ[INTEG_W-1];
        endcase
        w_gterm    = w_gneg ? (TERM_W'(0) - {1'b0, w_gmag}) : {1'b0, w_gmag};

        w_qcap     = cap_mag(MUL_P_W'(w_quo));

        w_isum     = $signed({r_integ[INTEG_W-1], r_integ})
                   + $signed({{(INTEG_W-TIME_W+1){r_corr[TIME_W-1]}}, r_corr});
        w_ilim     = $signed({2'b0, r_lim});
        w_iclamp   = (w_isum > w_ilim) ? w_ilim :
                     ((w_isum < -w_ilim) ? -w_ilim : w_isum);

        w_dsum     = $signed({{(TERM_W-RATE_W+1){r_da[RATE_W-1]}}, r_da})
                   + $signed({r_fterm[TERM_W-1], r_fterm});
        w_mfa_s    = $signed({{(TERM_W+1-47){1'b0}}, r_mfa});
        w_dclamp   = (w_dsum > w_mfa_s) ? w_mfa_s :
                     ((w_dsum < -w_mfa_s) ? -w_mfa_s : w_dsum);

        w_drift    = r_dneg ? (TERM_W'(0) - {1'b0, r_q}) : {1'b0, r_q};
        w_total    = 64'(r_da) + 64'(r_prop) + 64'(r_iterm);
        w_lock_ok  = r_omag < {1'b0, r_lock_thr};
        w_lock_inc = (&r_lock) ? r_lock : (r_lock + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_drift  <= RST_MAX_DRIFT;
            r_freq_thr   <= RST_FREQ_THR;
            r_coarse_thr <= RST_COARSE_THR;
            r_lock_thr   <= RST_LOCK_THR;
            r_kf         <= RST_GAIN_FREQ;
            r_kp         <= RST_GAIN_PROP;
            r_ki         <= RST_GAIN_INTEG;
            r_mfa        <= RST_MAX_FADJ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_DRIFT:  r_max_drift  <= i_cfg_data;
                CFG_FREQ_THR:   r_freq_thr   <= i_cfg_data;
                CFG_COARSE_THR: r_coarse_thr <= i_cfg_data[38:0];
                CFG_LOCK_THR:   r_lock_thr   <= i_cfg_data[38:0];
                CFG_GAIN_FREQ:  r_kf         <= i_cfg_data[31:0];
                CFG_GAIN_PROP:  r_kp         <= i_cfg_data[31:0];
                CFG_GAIN_INTEG: r_ki         <= i_cfg_data[31:0];
                default:        r_mfa        <= i_cfg_data;
            endcase
        end
    end

    // Working registers carry no reset; they are always written before use.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref_mag <= mag_time(i_ref_interval);
            r_dmag    <= w_diff_mag[TIME_W-1:0];
            r_dneg    <= w_diff[TIME_W] ^ i_ref_interval[TIME_W-1];
            r_omag    <= mag_time(i_clock_offset);
            r_corr    <= w_corr;
            r_cmag    <= mag_time(w_corr);
        end
        if (i_cmd.q_latch) begin
            r_q <= w_qcap;
        end
        if (i_cmd.lim_latch) begin
            r_lim <= (w_qcap > MAG_W'(LIM_MAX)) ? LIM_MAX : w_qcap[LIM_W-1:0];
        end else if (i_cmd.lim_zero) begin
            r_lim <= '0;
        end
        if (i_cmd.mul_latch) begin
            unique case (i_cmd.mul_dst)
                MD_FREQ:  r_fterm <= w_gterm;
                MD_PROP:  r_prop  <= w_gterm;
                default:  r_iterm <= w_gterm;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_da      <= '0;
            r_integ   <= '0;
            r_lock    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.integ_upd) begin
                r_integ <= w_iclamp[INTEG_W-1:0];
            end
            if (i_cmd.fin) begin
                r_o_valid <= 1'b1;
                unique case (i_cmd.kind)
                    MODE_NONE: begin
                    end
                    MODE_DRIFT_ERR: r_lock <= '0;
                    MODE_FREQ: begin
                        r_da    <= w_dclamp[RATE_W-1:0];
                        r_integ <= '0;
                        r_lock  <= '0;
                    end
                    MODE_COARSE: begin
                        r_integ <= '0;
                        r_lock  <= '0;
                    end
                    default: r_lock <= w_lock_ok ? w_lock_inc : '0;
                endcase
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_mode  <= i_cmd.kind;
            r_o_adj   <= 1'b0;
            r_o_step  <= 1'b0;
            r_o_fadj  <= '0;
            r_o_corr  <= '0;
            r_o_meas  <= sat_rate(64'(w_drift));
            r_o_fterm <= '0;
            r_o_prop  <= '0;
            r_o_iterm <= '0;
            r_o_lock  <= '0;
            unique case (i_cmd.kind)
                MODE_NONE: begin
                    r_o_meas <= '0;
                    r_o_lock <= r_lock;
                end
                MODE_DRIFT_ERR: begin
                end
                MODE_FREQ: begin
                    r_o_adj   <= 1'b1;
                    r_o_fadj  <= w_dclamp[RATE_W-1:0];
                    r_o_fterm <= w_dclamp[RATE_W-1:0];
                end
                MODE_COARSE: begin
                    r_o_step <= 1'b1;
                    r_o_corr <= r_corr;
                end
                default: begin
                    r_o_adj   <= 1'b1;
                    r_o_fadj  <= sat_rate(w_total);
                    r_o_corr  <= r_corr;
                    r_o_fterm <= r_da;
                    r_o_prop  <= sat_rate(64'(r_prop));
                    r_o_iterm <= sat_rate(64'(r_iterm));
                    r_o_lock  <= w_lock_ok ? w_lock_inc : '0;
                end
            endcase
        end
    end

    always_comb begin
        o_status.ref_zero   = (r_ref_mag == '0);
        o_status.mul_done   = w_mul_done;
        o_status.div_done   = w_div_done;
        o_status.drift_over = r_q > MAG_W'(r_max_drift);
        o_status.freq_sel   = r_q > MAG_W'(r_freq_thr);
        o_status.coarse_sel = r_omag > {1'b0, r_coarse_thr};
        o_status.ki_zero    = (r_ki == '0);
        o_status.out_free   = !r_o_valid || i_out_ready;
    end

    assign o_out_valid         = r_o_valid;
    assign o_mode              = r_o_mode;
    assign o_adjust_frequency  = r_o_adj;
    assign o_step_clock        = r_o_step;
    assign o_freq_adjust       = r_o_fadj;
    assign o_offset_correction = r_o_corr;
    assign o_measured_drift    = r_o_meas;
    assign o_freq_term         = r_o_fterm;
    assign o_prop_term         = r_o_prop;
    assign o_integ_term        = r_o_iterm;
    assign o_lock_count        = r_o_lock;
endmodule

/* rtl/core/pcs_ctrl.sv */
`timescale 1ns / 1ps
module pcs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pcs_pkg::t_status  i_status,
    output pcs_pkg::t_cmd     o_cmd
);
    import pcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_MUL_NS, S_DIV_DRIFT, S_CHECK, S_MUL_KF,
        S_DIV_LIM, S_INTEG, S_MUL_KP, S_MUL_KI, S_FINISH
    } t_state;

    t_state r_state, n_state;
    t_mode  r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= MODE_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_status.ref_zero) begin
                    n_kind  = MODE_NONE;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_NS;
                    n_state         = S_MUL_NS;
                end
            end
            S_MUL_NS: begin
                if (i_status.mul_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_DRIFT;
                    n_state         = S_DIV_DRIFT;
                end
            end
            S_DIV_DRIFT: begin
                if (i_status.div_done) begin
                    o_cmd.q_latch = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.drift_over) begin
                    n_kind  = MODE_DRIFT_ERR;
                    n_state = S_FINISH;
                end else if (i_status.freq_sel) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_KF;
                    n_state         = S_MUL_KF;
                end else if (i_status.coarse_sel) begin
                    n_kind  = MODE_COARSE;
                    n_state = S_FINISH;
                end else if (i_status.ki_zero) begin
                    o_cmd.lim_zero = 1'b1;
                    n_state        = S_INTEG;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_LIM;
                    n_state         = S_DIV_LIM;
                end
            end
            S_MUL_KF: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_latch = 1'b1;
                    o_cmd.mul_dst   = MD_FREQ;
                    n_kind          = MODE_FREQ;
                    n_state         = S_FINISH;
                end
            end
            S_DIV_LIM: begin
                if (i_status.div_done) begin
                    o_cmd.lim_latch = 1'b1;
                    n_state         = S_INTEG;
                end
            end
            S_INTEG: begin
                o_cmd.integ_upd = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_KP;
                n_state         = S_MUL_KP;
            end
            S_MUL_KP: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_latch = 1'b1;
                    o_cmd.mul_dst   = MD_PROP;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_KI;
                    n_state         = S_MUL_KI;
                end
            end
            S_MUL_KI: begin
                if (i_status.mul_done) begin
                    o_cmd.mul_latch = 1'b1;
                    o_cmd.mul_dst   = MD_INTEG;
                    n_kind          = MODE_FINE;
                    n_state         = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

/* rtl/core/ptp_clock_servo.sv */
`timescale 1ns / 1ps
// A zero reference interval skips the bit-serial divider and the shift-add multiplier;
// a drift error or coarse step uses one product and one division, frequency mode one more
// product, and fine mode the limit division (nonzero integral gain) and two more products.
// Throughput: one transaction at a time; the next is taken once the previous result has
// moved into the output register. Reset is synchronous and active low; it restores the
// configuration defaults and clears the drift accumulator, the integral and the lock count.
module ptp_clock_servo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pcs_pkg::CFG_W-1:0]         i_cfg_data,
    pcs_in_if.sink                            s_in,
    pcs_out_if.source                         m_out
);
    import pcs_pkg::*;

    // The controller sequences the shared multiplier and divider in the datapath.
    // Every transaction with a nonzero reference interval first forms the drift as a product
    // by 1e9 followed by a division by the reference interval. Fine mode then derives the
    // integral limit with a second division (zero for a zero integral gain) and forms the
    // proportional and integral terms with two more products, then fills the output register.

    t_cmd    w_cmd;
    t_status w_status;

    pcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_in.valid),
        .o_in_ready (s_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pcs_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_ref_interval      (s_in.ref_interval),
        .i_local_interval    (s_in.local_interval),
        .i_clock_offset      (s_in.clock_offset),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_out_ready         (m_out.ready),
        .o_out_valid         (m_out.valid),
        .o_mode              (m_out.mode),
        .o_adjust_frequency  (m_out.adjust_frequency),
        .o_step_clock        (m_out.step_clock),
        .o_freq_adjust       (m_out.freq_adjust),
        .o_offset_correction (m_out.offset_correction),
        .o_measured_drift    (m_out.measured_drift),
        .o_freq_term         (m_out.freq_term),
        .o_prop_term         (m_out.prop_term),
        .o_integ_term        (m_out.integ_term),
        .o_lock_count        (m_out.lock_count)
    );
endmodule
